### rtl/aescbc_pkg.sv
// shared types, constants and byte functions of the aes-128 cbc cipher
`timescale 1ns / 1ps
`default_nettype none

package aescbc_pkg;

    localparam int ROUNDS      = 10;
    localparam int KEY_ENTRIES = ROUNDS + 1;
    localparam int STEP_W      = 4;
    localparam int BLOCK_W     = 128;
    localparam int HALF_W      = 64;
    localparam int ADDR_W      = 6;

    typedef enum logic [2:0] {
        CFG_KEY_HIGH  = 3'd0,
        CFG_KEY_LOW   = 3'd1,
        CFG_IV_HIGH   = 3'd2,
        CFG_IV_LOW    = 3'd3,
        CFG_DIRECTION = 3'd4
    } cfg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_EXPAND = 5'b00010,
        ST_SETTLE = 5'b00100,
        ST_LOAD   = 5'b01000,
        ST_ROUND  = 5'b10000
    } state_t;

    typedef struct packed {
        logic              load;
        logic              expand;
        logic              rd_en;
        logic [STEP_W-1:0] step;
        logic [STEP_W-1:0] rd_addr;
    } ks_ctrl_t;

    localparam logic [2047:0] SBOX_FWD = {
        128'h637c777bf26b6fc53001672bfed7ab76,
        128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115,
        128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84,
        128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8,
        128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973,
        128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479,
        128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
        128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df,
        128'h8ca1890dbfe6426841992d0fb054bb16
    };

    localparam logic [2047:0] SBOX_INV = {
        128'h52096ad53036a538bf40a39e81f3d7fb,
        128'h7ce339829b2fff87348e4344c4dee9cb,
        128'h547b9432a6c2233dee4c950b42fac34e,
        128'h082ea16628d924b2765ba2496d8bd125,
        128'h72f8f66486689816d4a45ccc5d65b692,
        128'h6c704850fdedb9da5e154657a78d9d84,
        128'h90d8ab008cbcd30af7e45805b8b34506,
        128'hd02c1e8fca3f0f02c1afbd0301138a6b,
        128'h3a9111414f67dcea97f2cfcef0b4e673,
        128'h96ac7422e7ad3585e2f937e81c75df6e,
        128'h47f11a711d29c5896fb7620eaa18be1b,
        128'hfc563e4bc6d279209adbc0fe78cd5af4,
        128'h1fdda8338807c731b11210592780ec5f,
        128'h60517fa919b54a0d2de57a9f93c99cef,
        128'ha0e03b4dae2af5b0c8ebbb3c83539961,
        128'h172b047eba77d626e169146355210c7d
    };

    function automatic logic [7:0] sbox_fwd(input logic [7:0] b);
        sbox_fwd = SBOX_FWD[{~b, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] sbox_inv(input logic [7:0] b);
        sbox_inv = SBOX_INV[{~b, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

`default_nettype wire

### rtl/aescbc_round.sv
// one aes round, forward or inverse, shared over all rounds of a block
`timescale 1ns / 1ps
`default_nettype none

module aescbc_round
    import aescbc_pkg::*;
(
    input  logic [BLOCK_W-1:0] blk,
    input  logic [BLOCK_W-1:0] rk,
    input  logic               inverse,
    input  logic               last,
    output logic [BLOCK_W-1:0] blk_out
);

    function automatic logic [BLOCK_W-1:0] byte_subst(input logic [BLOCK_W-1:0] s,
                                                      input logic inv);
        logic [BLOCK_W-1:0] t;
        t = '0;
        for (int i = 0; i < 16; i++) begin
            t[BLOCK_W-1-8*i -: 8] = inv ? sbox_inv(s[BLOCK_W-1-8*i -: 8])
                                        : sbox_fwd(s[BLOCK_W-1-8*i -: 8]);
        end
        return t;
    endfunction

    function automatic logic [BLOCK_W-1:0] row_rotate(input logic [BLOCK_W-1:0] s,
                                                      input logic inv);
        logic [BLOCK_W-1:0] t;
        int src;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                src = inv ? ((c - r + 4) & 3) : ((c + r) & 3);
                t[BLOCK_W-1-8*(c*4+r) -: 8] = s[BLOCK_W-1-8*(src*4+r) -: 8];
            end
        end
        return t;
    endfunction

    function automatic logic [31:0] mix_fwd(input logic [31:0] col);
        logic [7:0] a0, a1, a2, a3;
        a0 = col[31:24];
        a1 = col[23:16];
        a2 = col[15:8];
        a3 = col[7:0];
        return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
    endfunction

    function automatic logic [31:0] mix_inv(input logic [31:0] col);
        logic [7:0] a [4];
        logic [7:0] m9 [4];
        logic [7:0] m11 [4];
        logic [7:0] m13 [4];
        logic [7:0] m14 [4];
        logic [7:0] x2, x4, x8;
        for (int k = 0; k < 4; k++) begin
            a[k]   = col[31-8*k -: 8];
            x2     = xtime(a[k]);
            x4     = xtime(x2);
            x8     = xtime(x4);
            m9[k]  = x8 ^ a[k];
            m11[k] = x8 ^ x2 ^ a[k];
            m13[k] = x8 ^ x4 ^ a[k];
            m14[k] = x8 ^ x4 ^ x2;
        end
        return {m14[0] ^ m11[1] ^ m13[2] ^ m9[3],
                m9[0] ^ m14[1] ^ m11[2] ^ m13[3],
                m13[0] ^ m9[1] ^ m14[2] ^ m11[3],
                m11[0] ^ m13[1] ^ m9[2] ^ m14[3]};
    endfunction

    function automatic logic [BLOCK_W-1:0] column_mix(input logic [BLOCK_W-1:0] s,
                                                      input logic inv);
        logic [BLOCK_W-1:0] t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            t[BLOCK_W-1-32*c -: 32] = inv ? mix_inv(s[BLOCK_W-1-32*c -: 32])
                                          : mix_fwd(s[BLOCK_W-1-32*c -: 32]);
        end
        return t;
    endfunction

    logic [BLOCK_W-1:0] enc_sr;
    logic [BLOCK_W-1:0] enc_out;
    logic [BLOCK_W-1:0] dec_ak;
    logic [BLOCK_W-1:0] dec_out;

    always_comb
    begin
        enc_sr  = row_rotate(byte_subst(blk, 1'b0), 1'b0);
        enc_out = (last ? enc_sr : column_mix(enc_sr, 1'b0)) ^ rk;
        dec_ak  = byte_subst(row_rotate(blk, 1'b1), 1'b1) ^ rk;
        dec_out = last ? dec_ak : column_mix(dec_ak, 1'b1);
        blk_out = inverse ? dec_out : enc_out;
    end

endmodule

`default_nettype wire

### rtl/aescbc_key_sched.sv
// round key expansion, one round key a cycle, and the round key store
`timescale 1ns / 1ps
`default_nettype none

module aescbc_key_sched
    import aescbc_pkg::*;
(
    input  logic               clk,
    input  ks_ctrl_t           ctrl,
    input  logic [BLOCK_W-1:0] key,
    output logic [BLOCK_W-1:0] rk
);

    function automatic logic [7:0] rcon(input logic [STEP_W-1:0] step);
        logic [7:0] r;
        case (step)
            4'd1:    r = 8'h01;
            4'd2:    r = 8'h02;
            4'd3:    r = 8'h04;
            4'd4:    r = 8'h08;
            4'd5:    r = 8'h10;
            4'd6:    r = 8'h20;
            4'd7:    r = 8'h40;
            4'd8:    r = 8'h80;
            4'd9:    r = 8'h1b;
            4'd10:   r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    logic [BLOCK_W-1:0] key_mem [KEY_ENTRIES];
    logic [BLOCK_W-1:0] kexp_reg;
    logic [BLOCK_W-1:0] kexp_next;
    logic [BLOCK_W-1:0] rk_reg;
    logic [31:0]        w0, w1, w2, w3, t, n0, n1, n2, n3;
    logic               wr_en;
    logic [STEP_W-1:0]  wr_addr;

    always_comb
    begin
        w0 = kexp_reg[127:96];
        w1 = kexp_reg[95:64];
        w2 = kexp_reg[63:32];
        w3 = kexp_reg[31:0];
        t  = {sbox_fwd(w3[23:16]) ^ rcon(ctrl.step), sbox_fwd(w3[15:8]),
              sbox_fwd(w3[7:0]), sbox_fwd(w3[31:24])};
        n0 = w0 ^ t;
        n1 = w1 ^ n0;
        n2 = w2 ^ n1;
        n3 = w3 ^ n2;
        kexp_next = ctrl.load ? key : {n0, n1, n2, n3};
        wr_en     = ctrl.load | ctrl.expand;
        wr_addr   = ctrl.load ? '0 : ctrl.step;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= kexp_next;
            kexp_reg         <= kexp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            rk_reg <= key_mem[ctrl.rd_addr];
        end
    end

    assign rk = rk_reg;

endmodule

`default_nettype wire

### rtl/aes128_cbc_block_cipher.sv
// aes-128 cbc cipher top level: sequencer, chain, config port and output register
//
// channel   dir  beat                         payload
// s_axis    in   one 128-bit block            tdata, tuser = first_block
// m_axis    out  one 128-bit result           tdata
// apb       in   64-bit register write/read   key, iv, direction
//
// a block goes from accept through one key add and ten passes through the
// single round unit; the next block is taken on the cycle the result is
// loaded, so a new block can enter as the last one leaves the rounds.
// the first block after a key write first runs key expansion and a settle state.
// reset clears chain, config and control; round keys are rebuilt on demand.
// a stalled output holds the last round until the output register frees.
`timescale 1ns / 1ps
`default_nettype none

module aes128_cbc_block_cipher
    import aescbc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [BLOCK_W-1:0] s_axis_tdata,   // data_high, data_low
    input  logic               s_axis_tuser,   // first_block
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [BLOCK_W-1:0] m_axis_tdata,   // result_high, result_low
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [HALF_W-1:0]  pwdata,
    output logic [HALF_W-1:0]  prdata,
    output logic               pready
);

    localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(ROUNDS);
    localparam logic [STEP_W-1:0] FIRST_STEP = STEP_W'(1);

    state_t             state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               keys_ready_reg, keys_ready_next;
    logic               out_valid_reg, out_valid_next;
    logic [BLOCK_W-1:0] chain_reg, chain_next;
    logic [HALF_W-1:0]  key_high_reg, key_low_reg, iv_high_reg, iv_low_reg;
    logic               dir_reg;
    logic [BLOCK_W-1:0] data_reg;
    logic [BLOCK_W-1:0] blk_reg, blk_next;
    logic [BLOCK_W-1:0] out_data_reg;

    cfg_idx_t           cfg_idx;
    logic               cfg_write;
    logic               s_accept;
    logic               last_step;
    logic               finishing;
    logic [BLOCK_W-1:0] din;
    logic [BLOCK_W-1:0] round_out;
    logic [BLOCK_W-1:0] result;
    logic [BLOCK_W-1:0] new_chain;
    logic [BLOCK_W-1:0] chain_now;
    logic [BLOCK_W-1:0] chain_in;
    logic [BLOCK_W-1:0] rk;
    logic [STEP_W-1:0]  start_addr;
    ks_ctrl_t           ks_ctrl;

    assign pready    = 1'b1;
    assign cfg_idx   = cfg_idx_t'(paddr[ADDR_W-1:3]);
    assign cfg_write = psel & penable & pwrite;

    always_comb
    begin
        case (cfg_idx)
            CFG_KEY_HIGH:  prdata = key_high_reg;
            CFG_KEY_LOW:   prdata = key_low_reg;
            CFG_IV_HIGH:   prdata = iv_high_reg;
            CFG_IV_LOW:    prdata = iv_low_reg;
            CFG_DIRECTION: prdata = {{(HALF_W-1){1'b0}}, dir_reg};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            iv_high_reg  <= '0;
            iv_low_reg   <= '0;
            dir_reg      <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                CFG_KEY_HIGH:  key_high_reg <= pwdata;
                CFG_KEY_LOW:   key_low_reg  <= pwdata;
                CFG_IV_HIGH:   iv_high_reg  <= pwdata;
                CFG_IV_LOW:    iv_low_reg   <= pwdata;
                CFG_DIRECTION: dir_reg      <= pwdata[0];
                default:       ;
            endcase
        end
    end

    assign din       = {s_axis_tdata[HALF_W-1:0], s_axis_tdata[BLOCK_W-1:HALF_W]};
    assign last_step = (step_reg == LAST_STEP);
    assign finishing = (state_reg == ST_ROUND) && last_step
                       && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = (state_reg == ST_IDLE) || finishing;
    assign s_accept  = s_axis_tvalid && s_axis_tready;

    aescbc_round u_round (
        .blk     (blk_reg),
        .rk      (rk),
        .inverse (dir_reg),
        .last    (last_step),
        .blk_out (round_out)
    );

    assign result    = dir_reg ? (round_out ^ chain_reg) : round_out;
    assign new_chain = dir_reg ? data_reg : round_out;
    assign chain_now = finishing ? new_chain : chain_reg;
    assign chain_in  = s_axis_tuser ? {iv_high_reg, iv_low_reg} : chain_now;

    // the key store read is registered, so its address runs ahead of its use
    assign start_addr = dir_reg ? LAST_STEP : '0;

    always_comb
    begin
        ks_ctrl.load   = s_accept && !keys_ready_reg;
        ks_ctrl.expand = (state_reg == ST_EXPAND);
        ks_ctrl.step   = step_reg;
        ks_ctrl.rd_en  = !((state_reg == ST_ROUND) && last_step && !finishing);
        case (state_reg)
            ST_LOAD:  ks_ctrl.rd_addr = dir_reg ? (LAST_STEP - FIRST_STEP) : FIRST_STEP;
            ST_ROUND:
            begin
                if (last_step)
                    ks_ctrl.rd_addr = start_addr;
                else if (dir_reg)
                    ks_ctrl.rd_addr = LAST_STEP - FIRST_STEP - step_reg;
                else
                    ks_ctrl.rd_addr = step_reg + FIRST_STEP;
            end
            default:  ks_ctrl.rd_addr = start_addr;
        endcase
    end

    aescbc_key_sched u_key_sched (
        .clk  (clk),
        .ctrl (ks_ctrl),
        .key  ({key_high_reg, key_low_reg}),
        .rk   (rk)
    );

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        keys_ready_next = keys_ready_reg;
        blk_next        = blk_reg;
        chain_next      = chain_reg;
        out_valid_next  = out_valid_reg;

        case (state_reg)
            ST_IDLE:   ;
            ST_EXPAND:
            begin
                if (last_step)
                begin
                    state_next      = ST_SETTLE;
                    keys_ready_next = 1'b1;
                end
                else
                    step_next = step_reg + FIRST_STEP;
            end
            ST_SETTLE: state_next = ST_LOAD;
            ST_LOAD:
            begin
                state_next = ST_ROUND;
                step_next  = FIRST_STEP;
                blk_next   = blk_reg ^ rk;
            end
            ST_ROUND:
            begin
                if (!last_step)
                begin
                    step_next = step_reg + FIRST_STEP;
                    blk_next  = round_out;
                end
                else if (finishing)
                begin
                    state_next = ST_IDLE;
                    chain_next = new_chain;
                end
            end
            default:   state_next = ST_IDLE;
        endcase

        if (finishing)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;

        if (s_accept)
        begin
            state_next = keys_ready_reg ? ST_LOAD : ST_EXPAND;
            step_next  = FIRST_STEP;
            blk_next   = dir_reg ? din : (din ^ chain_in);
            if (s_axis_tuser)
                chain_next = {iv_high_reg, iv_low_reg};
        end

        if (cfg_write && (cfg_idx == CFG_KEY_HIGH || cfg_idx == CFG_KEY_LOW))
            keys_ready_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            keys_ready_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            chain_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            keys_ready_reg <= keys_ready_next;
            out_valid_reg  <= out_valid_next;
            chain_reg      <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        if (s_accept)
            data_reg <= din;
        if (finishing)
            out_data_reg <= {result[HALF_W-1:0], result[BLOCK_W-1:HALF_W]};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

### rtl/aescbc_checker.sv
// port-level checks of the aes-128 cbc cipher and their binding
`timescale 1ns / 1ps
`default_nettype none

module aescbc_checker
    import aescbc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    input  logic               s_axis_tready,
    input  logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    input  logic [BLOCK_W-1:0] m_axis_tdata
);

    logic s_beat;

    assign s_beat = s_axis_tvalid && s_axis_tready;

    // result stays offered until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one block at a time through the round unit
    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        s_beat |=> !s_axis_tready)
        else $error("input taken while a block is in the rounds");

    // a fresh result cannot appear right after a block enters
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_beat |-> ##2 !$rose(m_axis_tvalid))
        else $error("result appeared too soon after input beat");

endmodule

bind aes128_cbc_block_cipher aescbc_checker u_checker (.*);

`default_nettype wire
